// ===== rtl/core/rvtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvtp_pkg
// Shared widths, codes and types of the reflux valve time proportioner.
// ----------------------------------------------------------------------------
package rvtp_pkg;

   // register and field widths
   localparam int RATIO_W  = 16;   // reflux ratio, unsigned Q8.8
   localparam int PERIOD_W = 12;   // cycle period in seconds
   localparam int CSR_W    = 16;   // widest register
   localparam int CSR_AW   = 1;    // register index width

   // span arithmetic widths
   localparam int TOTAL_W  = 22;   // period * 1000 fits 22 bits
   localparam int NUM_W    = TOTAL_W + RATIO_W;   // total * ratio
   localparam int DVD_W    = NUM_W + 1;           // plus rounding term
   localparam int DEN_W    = RATIO_W + 1;         // ratio + 1.0
   localparam int Q_W      = TOTAL_W;             // quotient never exceeds total

   localparam int MS_PER_S = 1000;
   localparam int Q8_ONE   = 256;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_RATIO  = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_PERIOD = 1'd1;

   // work mode codes
   localparam logic [1:0] MODE_OTHER   = 2'd0;
   localparam logic [1:0] MODE_RECT    = 2'd1;
   localparam logic [1:0] MODE_DISTILL = 2'd2;

   // column phase codes
   localparam logic [1:0] PH_HEADS = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_TAILS = 2'd2;
   localparam logic [1:0] PH_OTHER = 2'd3;

   // divider status toward the sequencer
   typedef struct packed {
      logic           busy;
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_result_type;

endpackage
`default_nettype wire

// ===== rtl/core/rvtp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvtp_div
// Restoring serial divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits Q_W bits, so only Q_W steps are run.
// ----------------------------------------------------------------------------
module rvtp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rvtp_pkg::DVD_W-1:0]  dividend,
   input  wire logic [rvtp_pkg::DEN_W-1:0]  divisor,
   output rvtp_pkg::div_result_type         result
);
   import rvtp_pkg::*;

   localparam int STEP_W = $clog2(Q_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    trial;

   // one trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[Q_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[DVD_W-1:Q_W];
         quo_in  = dividend[Q_W-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         // restore drops only a zero top bit: a failed trial means shifted < den
         rem_in = trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], ~trial[DEN_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign result.busy     = busy_ff;
   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/core/reflux_valve_time_proportioner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// reflux_valve_time_proportioner
// Time-proportional reflux valve drive for a rectification column.
// ----------------------------------------------------------------------------
// Each request beat is one millisecond tick with the run, pause, mode and
// column phase status; each tick yields exactly one response beat with the
// valve drive and the cycle phase. After acceptance the sequencer runs a
// multiply state each for the total and the dividend, a load state, 22 steps
// of the serial divider that forms ceil(period*1000*ratio/(ratio+1)), a wait
// state that captures the quotient and a decision state. The block takes no
// new tick until the response register is free for the current one. The user
// must write registers over the csr port only while idle; the block does not
// enforce it. Writing either register restarts the reflux/collect cycle.
// ----------------------------------------------------------------------------
module reflux_valve_time_proportioner #(
   parameter int COUNTER_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request: running, paused, work_mode[1:0], column_phase[1:0], zero pad
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   // response: valve_open, collect_phase, zero pad
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata,
   // register write port
   input  wire logic                          csr_wr_en,
   input  wire logic [rvtp_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [rvtp_pkg::CSR_W-1:0]    csr_wdata
);
   import rvtp_pkg::*;

   localparam int CMP_W = (COUNTER_BITS > Q_W) ? COUNTER_BITS : Q_W;

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_NUM   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [RATIO_W-1:0]      ratio_ff, ratio_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic                    valve_ff, valve_in;
   logic                    phase_ff, phase_in;
   logic                    switched_ff, switched_in;
   logic [COUNTER_BITS-1:0] ms_ff, ms_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_valve_ff, rsp_valve_in;
   logic                    rsp_phase_ff, rsp_phase_in;

   logic                    running_ff, paused_ff;
   logic [1:0]              mode_ff, col_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic [DVD_W-1:0]        num_ff;
   logic [Q_W-1:0]          reflux_ff;

   logic                    req_beat;
   logic                    out_free;
   logic [NUM_W-1:0]        product;
   logic [Q_W-1:0]          span;
   logic                    span_reached;
   logic                    div_start;
   div_result_type          div_res;

   assign req_beat   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == S_START);

   // dividend term: total * ratio, rounded up by adding den - 1
   assign product = NUM_W'(total_ff) * NUM_W'(ratio_ff);

   // span of the current phase against the elapsed time
   assign span = phase_ff ? (total_ff - reflux_ff) : reflux_ff;
   assign span_reached = CMP_W'(ms_ff) >= CMP_W'(span);

   rvtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (DEN_W'(ratio_ff) + DEN_W'(Q8_ONE)),
      .result   (div_res)
   );

   // sequencer and cycle state
   always_comb begin
      state_in     = state_ff;
      ratio_in     = ratio_ff;
      period_in    = period_ff;
      valve_in     = valve_ff;
      phase_in     = phase_ff;
      switched_in  = switched_ff;
      ms_in        = ms_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_valve_in = rsp_valve_ff;
      rsp_phase_in = rsp_phase_ff;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      // register writes restart the cycle
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_RATIO:  ratio_in  = csr_wdata[RATIO_W-1:0];
            CSR_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
         phase_in    = 1'b0;
         switched_in = 1'b0;
         ms_in       = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               // saturating millisecond count
               if (ms_ff != '1)
                  ms_in = ms_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL:   state_in = S_NUM;
         S_NUM:   state_in = S_START;
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (div_res.done)
               state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               if (running_ff && !paused_ff) begin
                  if (mode_ff == MODE_RECT && col_ff == PH_BODY) begin
                     if (ratio_ff == '0) begin
                        valve_in = 1'b1;
                     end else if (!switched_ff || span_reached) begin
                        phase_in    = !phase_ff;
                        valve_in    = !phase_ff;
                        switched_in = 1'b1;
                        ms_in       = '0;
                     end
                  end else if ((mode_ff == MODE_RECT &&
                                (col_ff == PH_HEADS || col_ff == PH_TAILS)) ||
                               mode_ff == MODE_DISTILL) begin
                     valve_in = 1'b1;
                  end else if (mode_ff == MODE_RECT) begin
                     valve_in = 1'b0;
                  end
               end else begin
                  valve_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_valve_in = valve_in;
               rsp_phase_in = phase_in;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ratio_ff     <= RATIO_W'(1280);
         period_ff    <= PERIOD_W'(60);
         valve_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         switched_ff  <= 1'b0;
         ms_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         period_ff    <= period_in;
         valve_ff     <= valve_in;
         phase_ff     <= phase_in;
         switched_ff  <= switched_in;
         ms_ff        <= ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and arithmetic operands
   always_ff @(posedge clock) begin
      rsp_valve_ff <= rsp_valve_in;
      rsp_phase_ff <= rsp_phase_in;
      if (req_beat) begin
         running_ff <= req_tdata[0];
         paused_ff  <= req_tdata[1];
         mode_ff    <= req_tdata[3:2];
         col_ff     <= req_tdata[5:4];
      end
      if (state_ff == S_MUL)
         total_ff <= TOTAL_W'(period_ff) * TOTAL_W'(MS_PER_S);
      if (state_ff == S_NUM)
         num_ff <= DVD_W'(product) + DVD_W'(ratio_ff) + DVD_W'(Q8_ONE - 1);
      if (state_ff == S_WAIT && div_res.done)
         reflux_ff <= div_res.quotient;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_phase_ff, rsp_valve_ff};

endmodule
`default_nettype wire

// ===== rtl/core/rvtp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvtp_checker
// Port-level checks of the reflux valve time proportioner.
// ----------------------------------------------------------------------------
module rvtp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [7:0]                    req_tdata,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [7:0]                    rsp_tdata,
   input wire logic                          csr_wr_en,
   input wire logic [rvtp_pkg::CSR_AW-1:0]   csr_addr,
   input wire logic [rvtp_pkg::CSR_W-1:0]    csr_wdata
);

   // a stalled response beat holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // a tick keeps the block busy for at least the next cycle
   a_busy_after_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a tick is in work");

   // pad bits of the response stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("response pad bits set");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind reflux_valve_time_proportioner rvtp_checker u_rvtp_checker (.*);
`default_nettype wire

// ===== sim/reflux_valve_time_proportioner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflux_valve_time_proportioner_test
// Self-checking bench for the reflux valve time proportioner.
// ----------------------------------------------------------------------------
// Ticks go in over the request stream and valve drive beats come back over
// the response stream. A behavioral copy of the valve logic predicts each
// response and a scoreboard checks them in order. A short table of directed
// ticks covers every mode and column phase; then a series of register
// settings (zero ratio, zero period, extreme ratios and periods) each runs a
// burst of random ticks, mostly body-phase rectification so that the
// reflux/collect spans actually expire. Both stream sides idle at random and
// the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module reflux_valve_time_proportioner_test;
   import rvtp_pkg::*;

   localparam int COUNTER_BITS = 32;
   localparam int IDLE_PCT     = 19;
   localparam logic [1:0] MODE_UNDEF = 2'd3;

   // one directed tick, with the expected beat where it is obvious
   typedef struct packed {
      logic       run;
      logic       pause;
      logic [1:0] mode;
      logic [1:0] col;
      logic       typed;
      logic       valve;
      logic       collect;
   } tick_row_type;

   typedef struct packed {
      logic valve_open;
      logic collect_phase;
   } valve_out_type;

   // reset config: ratio 5.0, period 60 s, so spans are far beyond this table
   localparam tick_row_type DIRECTED_TICKS [18] = '{
      {1'b0, 1'b0, MODE_RECT,    PH_BODY,  1'b1, 1'b0, 1'b0},  // stopped
      {1'b1, 1'b1, MODE_RECT,    PH_BODY,  1'b1, 1'b0, 1'b0},  // paused
      {1'b1, 1'b0, MODE_DISTILL, PH_HEADS, 1'b1, 1'b1, 1'b0},
      {1'b1, 1'b0, MODE_OTHER,   PH_BODY,  1'b1, 1'b1, 1'b0},  // hold
      {1'b1, 1'b0, MODE_UNDEF,   PH_BODY,  1'b1, 1'b1, 1'b0},  // hold
      {1'b1, 1'b0, MODE_RECT,    PH_OTHER, 1'b1, 1'b0, 1'b0},
      {1'b1, 1'b0, MODE_RECT,    PH_HEADS, 1'b1, 1'b1, 1'b0},
      {1'b1, 1'b0, MODE_RECT,    PH_TAILS, 1'b1, 1'b1, 1'b0},
      {1'b1, 1'b0, MODE_RECT,    PH_OTHER, 1'b1, 1'b0, 1'b0},
      {1'b1, 1'b0, MODE_RECT,    PH_BODY,  1'b1, 1'b1, 1'b1},  // first switch
      {1'b1, 1'b0, MODE_RECT,    PH_BODY,  1'b0, 1'b0, 1'b0},
      {1'b1, 1'b0, MODE_RECT,    PH_OTHER, 1'b1, 1'b0, 1'b1},
      {1'b1, 1'b0, MODE_RECT,    PH_BODY,  1'b0, 1'b0, 1'b0},
      {1'b1, 1'b1, MODE_UNDEF,   PH_OTHER, 1'b1, 1'b0, 1'b1},
      {1'b0, 1'b1, MODE_DISTILL, PH_TAILS, 1'b1, 1'b0, 1'b1},
      {1'b1, 1'b0, MODE_DISTILL, PH_OTHER, 1'b1, 1'b1, 1'b1},
      {1'b1, 1'b0, MODE_OTHER,   PH_OTHER, 1'b1, 1'b1, 1'b1},
      {1'b1, 1'b0, MODE_UNDEF,   PH_HEADS, 1'b1, 1'b1, 1'b1}
   };

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_wr_en  = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_W-1:0]  csr_wdata  = '0;

   // valve model state and its copy of the registers
   logic [RATIO_W-1:0]      ratio_q8;
   logic [PERIOD_W-1:0]     period_s;
   logic                    valve_now;
   logic                    phase_now;
   logic                    switched_now;
   logic [COUNTER_BITS-1:0] ms_count;

   valve_out_type pending_valve [$];
   int            ticks_sent       = 0;
   int            valve_beats_seen = 0;
   int            mismatch_count   = 0;
   int            hold_left        = 0;
   bit            held_once        = 1'b0;

   reflux_valve_time_proportioner #(
      .COUNTER_BITS(COUNTER_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #6_000_000;
      $display("reflux_valve_time_proportioner test failed");
      $finish;
   end

   // one millisecond tick through the valve model
   function automatic valve_out_type advance_valve(input logic [7:0] beat);
      logic              run;
      logic              pause;
      logic [1:0]        mode;
      logic [1:0]        col;
      longint unsigned   total;
      longint unsigned   den;
      longint unsigned   reflux_ms;
      longint unsigned   span;
      valve_out_type     res;
      run   = beat[0];
      pause = beat[1];
      mode  = beat[3:2];
      col   = beat[5:4];
      if (ms_count != '1)
         ms_count = ms_count + 1'b1;
      if (run && !pause) begin
         if (mode == MODE_RECT && col == PH_BODY) begin
            if (ratio_q8 == '0) begin
               valve_now = 1'b1;
            end else begin
               total     = 64'(period_s) * 64'(MS_PER_S);
               den       = 64'(ratio_q8) + 64'(Q8_ONE);
               reflux_ms = (total * 64'(ratio_q8) + den - 1) / den;
               span      = phase_now ? total - reflux_ms : reflux_ms;
               if (!switched_now || 64'(ms_count) >= span) begin
                  phase_now    = ~phase_now;
                  valve_now    = phase_now;
                  switched_now = 1'b1;
                  ms_count     = '0;
               end
            end
         end else if (mode == MODE_DISTILL || (mode == MODE_RECT && col != PH_OTHER)) begin
            valve_now = 1'b1;
         end else if (mode == MODE_RECT) begin
            valve_now = 1'b0;
         end
      end else begin
         valve_now = 1'b0;
      end
      res.valve_open    = valve_now;
      res.collect_phase = phase_now;
      return res;
   endfunction

   // write both registers back to back; either write restarts the cycle
   task automatic apply_setting(input logic [RATIO_W-1:0] ratio,
                                input logic [PERIOD_W-1:0] period);
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_RATIO;
      csr_wdata <= ratio;
      @(posedge clock);
      // bits above the period field are junk and must be ignored
      csr_addr  <= CSR_PERIOD;
      csr_wdata <= {(CSR_W-PERIOD_W)'($urandom), period};
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      ratio_q8     = ratio;
      period_s     = period;
      phase_now    = 1'b0;
      switched_now = 1'b0;
      ms_count     = '0;
   endtask

   // offer one tick beat, with random gaps outside the calm stretch
   task automatic send_tick(input logic [7:0] beat, input logic typed,
                            input valve_out_type typed_out);
      valve_out_type predicted;
      while (!(ticks_sent >= 900 && ticks_sent < 1200) &&
             $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_valve(beat);
      pending_valve.push_back(typed ? typed_out : predicted);
      ticks_sent++;
   endtask

   // stop offering and let every outstanding beat come back
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_valve.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed body ticks, then other rectification phases, then noise
   function automatic logic [7:0] random_tick;
      int roll;
      roll = $urandom_range(99);
      if (roll < 72)
         return {2'b00, PH_BODY, MODE_RECT, 1'b0, 1'b1};
      else if (roll < 85)
         return {2'b00, 2'($urandom_range(3)), MODE_RECT, 1'b0, 1'b1};
      else
         return {2'b00, 6'($urandom)};
   endfunction

   task automatic run_phase(input logic [RATIO_W-1:0] ratio,
                            input logic [PERIOD_W-1:0] period, input int count);
      apply_setting(ratio, period);
      repeat (count) send_tick(random_tick(), 1'b0, '0);
      drain();
   endtask

   // response side: random stalls, one calm stretch, one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!held_once && valve_beats_seen >= 1300) begin
         held_once  <= 1'b1;
         hold_left  <= 500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (valve_beats_seen >= 400 && valve_beats_seen < 700) ||
                       $urandom_range(99) >= IDLE_PCT;
      end
   end

   // scoreboard
   always @(posedge clock) begin
      valve_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_valve.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got %02h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_valve.pop_front();
            if (rsp_tdata[0] !== want.valve_open) begin
               $display("%0t: valve_open mismatch, expected %0b, got %0b",
                        $time, want.valve_open, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.collect_phase) begin
               $display("%0t: collect_phase mismatch, expected %0b, got %0b",
                        $time, want.collect_phase, rsp_tdata[1]);
               mismatch_count++;
            end
         end
         valve_beats_seen <= valve_beats_seen + 1;
      end
   end

   // main sequence
   initial begin
      ratio_q8     = 16'd1280;
      period_s     = 12'd60;
      valve_now    = 1'b0;
      phase_now    = 1'b0;
      switched_now = 1'b0;
      ms_count     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks under the reset setting
      foreach (DIRECTED_TICKS[i]) begin
         send_tick({2'b00, DIRECTED_TICKS[i].col, DIRECTED_TICKS[i].mode,
                    DIRECTED_TICKS[i].pause, DIRECTED_TICKS[i].run},
                   DIRECTED_TICKS[i].typed,
                   {DIRECTED_TICKS[i].valve, DIRECTED_TICKS[i].collect});
      end
      drain();

      // zero ratio holds the valve open
      run_phase('0, 12'($urandom_range(4095)), 200);
      // zero period switches on every body tick
      run_phase(16'($urandom_range(1, 65535)), '0, 250);
      // extreme ratio: 3 ms collect, 997 ms reflux
      run_phase(16'hFFFF, 12'd1, 250);
      // smallest ratio: 4 ms reflux, 996 ms collect
      run_phase(16'd1, 12'd1, 250);
      // ratio 1.0: 500 ms each way, long enough to see both switches
      run_phase(16'd256, 12'd1, 600);
      run_phase(16'hFFFF, 12'hFFF, 150);
      // period above the nominal 3600 s limit
      run_phase(16'($urandom_range(1, 65535)), 12'($urandom_range(3601, 4095)), 130);

      while (pending_valve.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("reflux_valve_time_proportioner test passed");
      else
         $display("reflux_valve_time_proportioner test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rvtp_pkg.sv
rtl/core/rvtp_div.sv
rtl/core/reflux_valve_time_proportioner.sv
rtl/core/rvtp_checker.sv
sim/reflux_valve_time_proportioner_test.sv
